>>> hw/rtl/bfmh_pkg.sv
`timescale 1ns / 1ps

package bfmh_pkg;

    localparam int FILTER_BITS_LOG2 = 16;
    localparam int WORD_BITS        = 32;
    localparam int BIT_SEL_W        = 5;
    localparam int WORD_AW          = FILTER_BITS_LOG2 - BIT_SEL_W;
    localparam int WORD_COUNT       = 1 << WORD_AW;

    localparam int KEY_W   = 32;
    localparam int POS_W   = 32;
    localparam int COUNT_W = 4;
    localparam int SHIFT_W = 5;
    localparam int PROBE_W = 3;
    localparam int PROBE_MAX = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - POS_W;

    localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_SHIFT = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [COUNT_W-1:0] HASH_COUNT_RESET  = 4'd4;
    localparam logic [SHIFT_W-1:0] INDEX_SHIFT_RESET = 5'd16;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [WORD_AW-1:0]   addr;
        logic [WORD_BITS-1:0] wr_data;
    } store_req_t;

    function automatic logic [KEY_W-1:0] mult_lookup(input logic [PROBE_W-1:0] probe);
        logic [KEY_W-1:0] m;
        case (probe)
            3'd0:    m = 32'd596572387;
            3'd1:    m = 32'd370248451;
            3'd2:    m = 32'd2654435769;
            3'd3:    m = 32'd1799596469;
            3'd4:    m = 32'h9e3779b1;
            3'd5:    m = 32'd2284105051;
            3'd6:    m = 32'd1203114875;
            default: m = 32'd1150766481;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/bfmh_bit_store.sv
`timescale 1ns / 1ps

module bfmh_bit_store
    import bfmh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  store_req_t           req,
    output logic [WORD_BITS-1:0] rd_data,
    output logic                 busy
);

    logic [WORD_BITS-1:0] filter_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WORD_AW-1:0]   clr_addr_reg;
    logic                 clr_busy_reg;

    // After reset every word is swept to zero, one word per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == WORD_AW'(WORD_COUNT - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            filter_mem[clr_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            filter_mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= filter_mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

>>> hw/rtl/bloom_filter_mul_hash.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                               Item
// s_*       in         tvalid tready tdata tuser tlast     one key to insert or query
// m_*       out        tvalid tready tdata                 hit flag and query position
// cfg_*     in         valid ready index data              one register write
//
// For an item with n probes (hash_count clamped to 1..8), each probe runs through the
// shared multiplier, a filter word read and a write-back or bit test.
// A query stops at its first clear bit.
// After reset the filter memory is cleared word by word; s_tready stays low meanwhile.
// A waiting result sits in the output register while the next item is worked on; the
// item finishes only once that register is free.
module bloom_filter_mul_hash
    import bfmh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [KEY_W-1:0]       s_tdata,   // [31:0] key
    input  logic                   s_tuser,   // [0] op
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] hit, [32:1] position, [39:33] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [COUNT_W-1:0]       hash_count_reg;
    logic [SHIFT_W-1:0]       index_shift_reg;
    logic [KEY_W-1:0]         key_reg;
    logic                     op_reg;
    logic                     last_reg;
    logic [PROBE_W-1:0]       probe_reg;
    logic [PROBE_W-1:0]       probe_last_reg;
    logic [KEY_W-1:0]         prod_reg;
    logic [WORD_AW-1:0]       word_reg;
    logic [BIT_SEL_W-1:0]     bit_pos_reg;
    logic                     hit_reg;
    logic                     m_tvalid_reg;
    logic                     hit_out_reg;
    logic [POS_W-1:0]         pos_out_reg;
    logic [POS_W-1:0]         query_pos_reg;

    logic [PROBE_W-1:0]          probe_last_next;
    logic [COUNT_W-1:0]          count_minus_one;
    logic [KEY_W-1:0]            prod_next;
    logic [KEY_W-1:0]            shifted;
    logic [FILTER_BITS_LOG2-1:0] bit_idx;
    logic [WORD_AW-1:0]          word_idx;
    logic                        probe_bit;
    logic                        is_last_probe;
    logic                        out_free;
    logic                        out_load;
    logic                        accept;
    store_req_t                  store_req;
    logic [WORD_BITS-1:0]        store_rd_data;
    logic                        store_busy;

    bfmh_bit_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (store_rd_data),
        .busy    (store_busy)
    );

    assign s_tready  = (state_reg == ST_IDLE) && !store_busy;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Out-of-range probe counts clamp to 1..8; the register holds the index of the last probe.
    assign count_minus_one = hash_count_reg - 1'b1;
    always_comb
    begin
        if (hash_count_reg == '0)
        begin
            probe_last_next = '0;
        end
        else if (hash_count_reg > COUNT_W'(PROBE_MAX))
        begin
            probe_last_next = PROBE_W'(PROBE_MAX - 1);
        end
        else
        begin
            probe_last_next = count_minus_one[PROBE_W-1:0];
        end
    end

    assign prod_next     = key_reg * mult_lookup(probe_reg);
    assign shifted       = prod_reg >> index_shift_reg;
    assign bit_idx       = shifted[FILTER_BITS_LOG2-1:0];
    assign word_idx      = bit_idx[FILTER_BITS_LOG2-1:BIT_SEL_W];
    assign probe_bit     = store_rd_data[bit_pos_reg];
    assign is_last_probe = (probe_reg == probe_last_reg);
    assign out_free      = !m_tvalid_reg || m_tready;
    assign out_load      = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        store_req.rd_en   = (state_reg == ST_READ);
        store_req.wr_en   = (state_reg == ST_UPDATE) && (op_reg == OP_INSERT);
        store_req.addr    = (state_reg == ST_READ) ? word_idx : word_reg;
        store_req.wr_data = store_rd_data | (WORD_BITS'(1) << bit_pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_count_reg  <= HASH_COUNT_RESET;
            index_shift_reg <= INDEX_SHIFT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HASH_COUNT:  hash_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_INDEX_SHIFT: index_shift_reg <= cfg_data[SHIFT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_reg        <= '0;
            op_reg         <= OP_INSERT;
            last_reg       <= 1'b0;
            probe_reg      <= '0;
            probe_last_reg <= '0;
            prod_reg       <= '0;
            word_reg       <= '0;
            bit_pos_reg    <= '0;
            hit_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            hit_out_reg    <= 1'b0;
            pos_out_reg    <= '0;
            query_pos_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg        <= s_tdata;
                        op_reg         <= s_tuser;
                        last_reg       <= s_tlast;
                        probe_reg      <= '0;
                        probe_last_reg <= probe_last_next;
                        hit_reg        <= 1'b1;
                        state_reg      <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    word_reg    <= word_idx;
                    bit_pos_reg <= bit_idx[BIT_SEL_W-1:0];
                    state_reg   <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if ((op_reg == OP_QUERY) && !probe_bit)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_FINISH;
                    end
                    else if (is_last_probe)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 1'b1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        if (op_reg == OP_QUERY)
                        begin
                            hit_out_reg   <= hit_reg;
                            pos_out_reg   <= query_pos_reg;
                            query_pos_reg <= last_reg ? '0 : query_pos_reg + 1'b1;
                        end
                        else
                        begin
                            hit_out_reg <= 1'b0;
                            pos_out_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, pos_out_reg, hit_out_reg};

endmodule

>>> hw/rtl/bfmh_checker.sv
`timescale 1ns / 1ps

module bfmh_checker
    import bfmh_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // Only one item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is still in progress");

    // A result does not appear too early after accepting its item.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 !$rose(m_tvalid))
        else $error("result appeared too early after accept");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:POS_W+1] == '0)
        else $error("padding bits of result are not zero");

endmodule

bind bloom_filter_mul_hash bfmh_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
